[rtl/dtsv_pkg.sv]
// shared types, constants and helpers of the date-time string validator
`timescale 1ns / 1ps
`default_nettype none

package dtsv_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned ACC_W  = 7;
  localparam int unsigned DIG_W  = 4;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [ACC_W-1:0]  acc_t;
  typedef logic [DIG_W-1:0]  digit_t;

  // character codes
  localparam char_t CHR_ZERO  = 8'h30;
  localparam char_t CHR_NINE  = 8'h39;
  localparam char_t CHR_COLON = 8'h3A;
  localparam char_t CHR_SPACE = 8'h20;

  // layout of dd:MM:yyyy hh:mm:ss
  localparam pos_t POS_DAY0    = 5'd0;
  localparam pos_t POS_DAY1    = 5'd1;
  localparam pos_t POS_SEP_DM  = 5'd2;
  localparam pos_t POS_MON0    = 5'd3;
  localparam pos_t POS_MON1    = 5'd4;
  localparam pos_t POS_SEP_MY  = 5'd5;
  localparam pos_t POS_CENT0   = 5'd6;
  localparam pos_t POS_CENT1   = 5'd7;
  localparam pos_t POS_YR0     = 5'd8;
  localparam pos_t POS_YR1     = 5'd9;
  localparam pos_t POS_SEP_DT  = 5'd10;
  localparam pos_t POS_HR0     = 5'd11;
  localparam pos_t POS_HR1     = 5'd12;
  localparam pos_t POS_SEP_HM  = 5'd13;
  localparam pos_t POS_MIN0    = 5'd14;
  localparam pos_t POS_MIN1    = 5'd15;
  localparam pos_t POS_SEP_MS  = 5'd16;
  localparam pos_t POS_SEC0    = 5'd17;
  localparam pos_t POS_SEC1    = 5'd18;
  localparam pos_t POS_FULL    = 5'd19;
  localparam pos_t POS_SAT     = 5'd20;

  // value limits
  localparam acc_t DAY_MIN   = 7'd1;
  localparam acc_t DAY_MAX   = 7'd31;
  localparam acc_t DAY_30    = 7'd30;
  localparam acc_t DAY_FEB   = 7'd28;
  localparam acc_t DAY_FEB_L = 7'd29;
  localparam acc_t MON_MIN   = 7'd1;
  localparam acc_t MON_MAX   = 7'd12;
  localparam acc_t MON_FEB   = 7'd2;
  localparam acc_t MON_APR   = 7'd4;
  localparam acc_t MON_JUN   = 7'd6;
  localparam acc_t MON_SEP   = 7'd9;
  localparam acc_t MON_NOV   = 7'd11;
  localparam acc_t HOUR_MAX  = 7'd23;
  localparam acc_t MS_MAX    = 7'd59;

  // shift one decimal digit into a two-digit accumulator
  function automatic acc_t push_digit(input acc_t acc, input digit_t dig);
    logic [ACC_W+3:0] sum;
    sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{(ACC_W){1'b0}}, dig};
    return sum[ACC_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/dtsv_if.sv]
// valid/ready channels for characters in and verdicts out
`timescale 1ns / 1ps
`default_nettype none

interface dtsv_in_if;
  logic                 valid;
  logic                 ready;
  dtsv_pkg::char_t      char_in;
  logic                 last;

  modport source (output valid, output char_in, output last, input ready);
  modport sink   (input valid, input char_in, input last, output ready);
endinterface

interface dtsv_out_if;
  logic valid;
  logic ready;
  logic valid_res;

  modport source (output valid, output valid_res, input ready);
  modport sink   (input valid, input valid_res, output ready);
endinterface

`default_nettype wire

[rtl/datetime_string_validator.sv]
// top level: streaming validator for dd:MM:yyyy hh:mm:ss timestamp strings
`timescale 1ns / 1ps
`default_nettype none

// one character word per cycle enters on in_i; the word flagged last closes the
// string and yields one verdict word on out_o (1 = well formed, in range and the
// day fits the month, Gregorian leap years included). a string must be exactly
// 19 characters; field characters must be digits, separators exact. throughput
// is one character per cycle save for the stall below: a word is held in the
// input register, then updates the position and digit accumulators while the
// verdict, if last, goes to the result register. a non-last character keeps
// flowing even while a verdict waits to be taken; only a second last character
// stalls behind an untaken verdict. after each verdict all state clears so the
// next word starts a new string.
module datetime_string_validator (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  dtsv_in_if.sink         in_i,
  dtsv_out_if.source      out_o
);

  // input register
  logic              s1_valid_q, s1_valid_d;
  dtsv_pkg::char_t   s1_char_q;
  logic              s1_last_q;

  // string state
  dtsv_pkg::pos_t    pos_q, pos_d;
  dtsv_pkg::acc_t    day_q, day_d;
  dtsv_pkg::acc_t    mon_q, mon_d;
  dtsv_pkg::acc_t    cent_q, cent_d;    // first two year digits
  dtsv_pkg::acc_t    yr_q, yr_d;        // last two year digits
  dtsv_pkg::acc_t    hour_q, hour_d;
  dtsv_pkg::acc_t    min_q, min_d;
  dtsv_pkg::acc_t    sec_q, sec_d;
  logic              bad_q, bad_d;

  // result register
  logic              out_valid_q, out_valid_d;
  logic              res_q;

  // values after the current character, before end-of-string clear
  dtsv_pkg::pos_t    nx_pos;
  dtsv_pkg::acc_t    nx_day, nx_mon, nx_cent, nx_yr, nx_hour, nx_min, nx_sec;
  logic              nx_bad;

  logic              is_dig;
  dtsv_pkg::digit_t  dig;
  logic              stall;
  logic              in_fire;
  logic              s1_fire;
  logic              fin;
  logic              leap;
  dtsv_pkg::acc_t    day_lim;
  logic              verdict;

  // only a finished string waiting behind an untaken verdict holds the pipe
  assign stall   = s1_valid_q && s1_last_q && out_valid_q && !out_o.ready;
  assign s1_fire = s1_valid_q && !stall;
  assign fin     = s1_fire && s1_last_q;

  assign in_i.ready = !stall;
  assign in_fire    = in_i.valid && in_i.ready;

  assign s1_valid_d = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);

  assign is_dig = (s1_char_q >= dtsv_pkg::CHR_ZERO) && (s1_char_q <= dtsv_pkg::CHR_NINE);
  assign dig    = is_dig ? dtsv_pkg::digit_t'(s1_char_q - dtsv_pkg::CHR_ZERO) : '0;

  // per-character field decode and accumulate
  always_comb begin
    nx_day  = day_q;
    nx_mon  = mon_q;
    nx_cent = cent_q;
    nx_yr   = yr_q;
    nx_hour = hour_q;
    nx_min  = min_q;
    nx_sec  = sec_q;
    nx_bad  = bad_q;
    unique case (pos_q) inside
      dtsv_pkg::POS_SEP_DM, dtsv_pkg::POS_SEP_MY,
      dtsv_pkg::POS_SEP_HM, dtsv_pkg::POS_SEP_MS: begin
        if (s1_char_q != dtsv_pkg::CHR_COLON) nx_bad = 1'b1;
      end
      dtsv_pkg::POS_SEP_DT: begin
        if (s1_char_q != dtsv_pkg::CHR_SPACE) nx_bad = 1'b1;
      end
      [dtsv_pkg::POS_DAY0:dtsv_pkg::POS_DAY1]: begin
        if (!is_dig) nx_bad = 1'b1;
        else nx_day = dtsv_pkg::push_digit(day_q, dig);
      end
      [dtsv_pkg::POS_MON0:dtsv_pkg::POS_MON1]: begin
        if (!is_dig) nx_bad = 1'b1;
        else nx_mon = dtsv_pkg::push_digit(mon_q, dig);
      end
      [dtsv_pkg::POS_CENT0:dtsv_pkg::POS_CENT1]: begin
        if (!is_dig) nx_bad = 1'b1;
        else nx_cent = dtsv_pkg::push_digit(cent_q, dig);
      end
      [dtsv_pkg::POS_YR0:dtsv_pkg::POS_YR1]: begin
        if (!is_dig) nx_bad = 1'b1;
        else nx_yr = dtsv_pkg::push_digit(yr_q, dig);
      end
      [dtsv_pkg::POS_HR0:dtsv_pkg::POS_HR1]: begin
        if (!is_dig) nx_bad = 1'b1;
        else nx_hour = dtsv_pkg::push_digit(hour_q, dig);
      end
      [dtsv_pkg::POS_MIN0:dtsv_pkg::POS_MIN1]: begin
        if (!is_dig) nx_bad = 1'b1;
        else nx_min = dtsv_pkg::push_digit(min_q, dig);
      end
      [dtsv_pkg::POS_SEC0:dtsv_pkg::POS_SEC1]: begin
        if (!is_dig) nx_bad = 1'b1;
        else nx_sec = dtsv_pkg::push_digit(sec_q, dig);
      end
      default: begin
        // too long
        nx_bad = 1'b1;
      end
    endcase
  end

  assign nx_pos = (pos_q < dtsv_pkg::POS_SAT) ? pos_q + dtsv_pkg::pos_t'(1) : pos_q;

  // leap year from the two digit pairs: yy % 4 on the low pair, century on the high
  assign leap = ((nx_yr[1:0] == 2'b00) && (nx_yr != '0)) ||
                ((nx_yr == '0) && (nx_cent[1:0] == 2'b00));

  // days allowed in the month
  always_comb begin
    case (nx_mon) inside
      dtsv_pkg::MON_FEB: day_lim = leap ? dtsv_pkg::DAY_FEB_L : dtsv_pkg::DAY_FEB;
      dtsv_pkg::MON_APR, dtsv_pkg::MON_JUN,
      dtsv_pkg::MON_SEP, dtsv_pkg::MON_NOV: day_lim = dtsv_pkg::DAY_30;
      default: day_lim = dtsv_pkg::DAY_MAX;
    endcase
  end

  assign verdict = !nx_bad && (nx_pos == dtsv_pkg::POS_FULL) &&
                   (nx_day >= dtsv_pkg::DAY_MIN) && (nx_day <= day_lim) &&
                   (nx_mon >= dtsv_pkg::MON_MIN) && (nx_mon <= dtsv_pkg::MON_MAX) &&
                   (nx_hour <= dtsv_pkg::HOUR_MAX) && (nx_min <= dtsv_pkg::MS_MAX) &&
                   (nx_sec <= dtsv_pkg::MS_MAX);

  // commit the character, or clear for a new string after the verdict
  always_comb begin
    pos_d  = pos_q;
    day_d  = day_q;
    mon_d  = mon_q;
    cent_d = cent_q;
    yr_d   = yr_q;
    hour_d = hour_q;
    min_d  = min_q;
    sec_d  = sec_q;
    bad_d  = bad_q;
    if (fin) begin
      pos_d  = '0;
      day_d  = '0;
      mon_d  = '0;
      cent_d = '0;
      yr_d   = '0;
      hour_d = '0;
      min_d  = '0;
      sec_d  = '0;
      bad_d  = 1'b0;
    end else if (s1_fire) begin
      pos_d  = nx_pos;
      day_d  = nx_day;
      mon_d  = nx_mon;
      cent_d = nx_cent;
      yr_d   = nx_yr;
      hour_d = nx_hour;
      min_d  = nx_min;
      sec_d  = nx_sec;
      bad_d  = nx_bad;
    end
  end

  assign out_valid_d = fin ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      pos_q       <= '0;
      day_q       <= '0;
      mon_q       <= '0;
      cent_q      <= '0;
      yr_q        <= '0;
      hour_q      <= '0;
      min_q       <= '0;
      sec_q       <= '0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      pos_q       <= pos_d;
      day_q       <= day_d;
      mon_q       <= mon_d;
      cent_q      <= cent_d;
      yr_q        <= yr_d;
      hour_q      <= hour_d;
      min_q       <= min_d;
      sec_q       <= sec_d;
      bad_q       <= bad_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_char_q <= in_i.char_in;
      s1_last_q <= in_i.last;
    end
    if (fin) begin
      res_q <= verdict;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.valid_res = res_q;

  // position never runs past saturation
  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= dtsv_pkg::POS_SAT)
    else $error("position above saturation");

  // end of string leaves a clean state
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |=> (pos_q == '0) && !bad_q)
    else $error("state not cleared after verdict");

  // a verdict word only appears after a last character was processed
  a_rose: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(fin))
    else $error("verdict without a closing character");

  // a positive verdict needs the closing character at the final position
  a_pass_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin && verdict) |-> (pos_q == dtsv_pkg::POS_SEC1) && is_dig)
    else $error("pass verdict on wrong length");

endmodule

`default_nettype wire
